/* design/gwwb_pkg.sv */
package gwwb_pkg;

    localparam int unsigned WIDTH_BITS  = 24;
    localparam int unsigned CODE_BITS   = 21;
    localparam int unsigned IDX_BITS    = 16;
    localparam int unsigned ADV_BITS    = 16;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

    localparam logic [CODE_BITS-1:0] CH_NEWLINE = 21'h00000A;
    localparam logic [CODE_BITS-1:0] CH_SPACE   = 21'h000020;
    localparam logic [CODE_BITS-1:0] CH_HYPHEN  = 21'h00002D;

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic                 first;
        logic [IDX_BITS-1:0]  index;
        logic [CODE_BITS-1:0] code;
        logic [ADV_BITS-1:0]  advance;
    } in_word_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] line_last;
        logic [IDX_BITS-1:0] line_next;
    } out_word_t;

    typedef enum logic [2:0] {
        KIND_OTHER,
        KIND_NEWLINE,
        KIND_SPACE,
        KIND_HYPHEN,
        KIND_END
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic                first;
        logic [IDX_BITS-1:0] index;
        logic [ADV_BITS-1:0] advance;
    } q_entry_t;

    typedef enum logic [1:0] {
        PH_DONE,
        PH_SCAN,
        PH_SKIP
    } phase_t;

endpackage

/* design/gwwb_front.sv */
module gwwb_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  gwwb_pkg::in_word_t s_word,
    output logic               q_valid,
    input  logic               q_ready,
    output gwwb_pkg::q_entry_t q_entry
);

    gwwb_pkg::kind_t kind;

    always_comb begin
        if (s_word.mode == gwwb_pkg::MODE_END) begin
            kind = gwwb_pkg::KIND_END;
        end else if (s_word.code == gwwb_pkg::CH_NEWLINE) begin
            kind = gwwb_pkg::KIND_NEWLINE;
        end else if (s_word.code == gwwb_pkg::CH_SPACE) begin
            kind = gwwb_pkg::KIND_SPACE;
        end else if (s_word.code == gwwb_pkg::CH_HYPHEN) begin
            kind = gwwb_pkg::KIND_HYPHEN;
        end else begin
            kind = gwwb_pkg::KIND_OTHER;
        end
    end

    // the code point is not needed past this point, only its class
    assign q_entry.kind    = kind;
    assign q_entry.first   = s_word.first;
    assign q_entry.index   = s_word.index;
    assign q_entry.advance = s_word.advance;

    assign q_valid = s_valid;
    assign s_ready = q_ready;

endmodule

/* design/gwwb_queue.sv */
module gwwb_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  gwwb_pkg::q_entry_t push_entry,
    output logic               pop_valid,
    input  logic               pop_ready,
    output gwwb_pkg::q_entry_t pop_entry
);

    localparam int unsigned PTR_BITS = $clog2(gwwb_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(gwwb_pkg::QUEUE_DEPTH + 1);

    gwwb_pkg::q_entry_t  mem [gwwb_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != CNT_BITS'(gwwb_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_BITS'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

endmodule

/* design/gwwb_back.sv */
module gwwb_back #(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [gwwb_pkg::WIDTH_BITS-1:0]     cfg_wdata,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  gwwb_pkg::q_entry_t                  q_entry,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gwwb_pkg::out_word_t                 m_word
);

    localparam int unsigned WB = gwwb_pkg::WIDTH_BITS;

    logic [WB-1:0]         line_width_reg;
    gwwb_pkg::phase_t      phase_reg, phase_next;
    logic [WB-1:0]         used_reg, used_next;
    logic [INDEX_BITS-1:0] word_start_reg, word_start_next;
    logic [INDEX_BITS-1:0] last_end_reg, last_end_next;
    logic [INDEX_BITS-1:0] start_reg, start_next;
    logic [INDEX_BITS-1:0] newline_reg, newline_next;

    logic                  m_valid_reg;
    gwwb_pkg::out_word_t   m_word_reg;

    gwwb_pkg::phase_t      ph;
    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS-1:0] idx_inc;
    logic [WB:0]           sum;
    logic [WB-1:0]         used_sat;
    logic                  pop;
    logic                  emit;
    logic [INDEX_BITS-1:0] res_last;
    logic [INDEX_BITS-1:0] res_next;

    // a word is taken only when the output register is free or draining
    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    assign idx      = INDEX_BITS'(q_entry.index);
    assign idx_inc  = idx + INDEX_BITS'(1);
    assign sum      = {1'b0, (q_entry.first ? {WB{1'b0}} : used_reg)}
                      + (WB + 1)'(q_entry.advance);
    assign used_sat = sum[WB] ? gwwb_pkg::WIDTH_MAX : sum[WB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= gwwb_pkg::WIDTH_MAX;
        end else if (cfg_wen) begin
            line_width_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= gwwb_pkg::PH_DONE;
            used_reg       <= '0;
            word_start_reg <= '0;
            last_end_reg   <= '0;
            start_reg      <= '0;
            newline_reg    <= '0;
        end else if (pop) begin
            phase_reg      <= phase_next;
            used_reg       <= used_next;
            word_start_reg <= word_start_next;
            last_end_reg   <= last_end_next;
            start_reg      <= start_next;
            newline_reg    <= newline_next;
        end
    end

    always_comb begin
        // a first word restarts the call whatever the phase
        if (q_entry.first) begin
            ph              = gwwb_pkg::PH_SCAN;
            used_next       = '0;
            word_start_next = idx;
            last_end_next   = idx;
            start_next      = idx;
            newline_next    = '0;
        end else begin
            ph              = phase_reg;
            used_next       = used_reg;
            word_start_next = word_start_reg;
            last_end_next   = last_end_reg;
            start_next      = start_reg;
            newline_next    = newline_reg;
        end
        phase_next = ph;
        emit       = 1'b0;
        res_last   = idx;
        res_next   = idx;

        unique case (ph)
            gwwb_pkg::PH_SKIP: begin
                if (q_entry.kind != gwwb_pkg::KIND_SPACE) begin
                    emit       = 1'b1;
                    res_last   = newline_next;
                    phase_next = gwwb_pkg::PH_DONE;
                end
            end
            gwwb_pkg::PH_SCAN: begin
                if (q_entry.kind == gwwb_pkg::KIND_END) begin
                    emit       = 1'b1;
                    phase_next = gwwb_pkg::PH_DONE;
                end else begin
                    used_next = used_sat;
                    case (q_entry.kind) inside
                        gwwb_pkg::KIND_NEWLINE: begin
                            newline_next = idx;
                            phase_next   = gwwb_pkg::PH_SKIP;
                        end
                        gwwb_pkg::KIND_SPACE, gwwb_pkg::KIND_HYPHEN: begin
                            if (word_start_next != idx) begin
                                last_end_next = idx;
                            end
                            word_start_next = idx_inc;
                        end
                        default: begin
                            if (used_sat >= line_width_reg) begin
                                emit       = 1'b1;
                                phase_next = gwwb_pkg::PH_DONE;
                                // break at the last word end if the line has one
                                if (last_end_next != start_next) begin
                                    res_last = last_end_next;
                                    res_next = word_start_next;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            m_word_reg.line_last <= gwwb_pkg::IDX_BITS'(res_last);
            m_word_reg.line_next <= gwwb_pkg::IDX_BITS'(res_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    a_done_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && emit |=> phase_reg == gwwb_pkg::PH_DONE)
        else $error("phase not done after a result");

    a_silent_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !q_entry.first && phase_reg == gwwb_pkg::PH_DONE |-> !emit)
        else $error("result from a finished call");

    a_width_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !q_entry.first && phase_reg == gwwb_pkg::PH_SCAN
            |=> used_reg >= $past(used_reg))
        else $error("used width fell within a call");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_word_reg))
        else $error("pending result overwritten");

endmodule

/* design/greedy_word_wrap_breaker.sv */
// Greedy word-wrap breaker: one word per cycle in and at most one result per
// call out. Each input word is classified and queued (four entries), and the
// break engine updates the running width with one saturating add and compare
// per cycle, so the sustained rate is one word per clock while m_ready is
// high; each result is registered as its word leaves the queue. The engine
// stalls only while its output register holds an untaken result; the queue
// then absorbs up to four further words before s_ready falls. The user writes
// line_width through cfg_wen/cfg_wdata while idle; the block does not check.
module greedy_word_wrap_breaker #(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [gwwb_pkg::WIDTH_BITS-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gwwb_pkg::in_word_t              s_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output gwwb_pkg::out_word_t             m_word
);

    logic               fq_valid;
    logic               fq_ready;
    gwwb_pkg::q_entry_t fq_entry;
    logic               qb_valid;
    logic               qb_ready;
    gwwb_pkg::q_entry_t qb_entry;

    gwwb_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_entry (fq_entry)
    );

    gwwb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_entry (fq_entry),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_entry  (qb_entry)
    );

    gwwb_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_entry   (qb_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

/* tb/greedy_word_wrap_breaker_tb.sv */
`timescale 1ns / 1ps

module greedy_word_wrap_breaker_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_WORDS = 20;

    localparam logic [gwwb_pkg::CODE_BITS-1:0] CH_LETTER_A = 21'h000061;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wen   = 1'b0;
    logic [gwwb_pkg::WIDTH_BITS-1:0] cfg_wdata = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    gwwb_pkg::in_word_t              s_word    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    gwwb_pkg::out_word_t             m_word;

    // mirror of the breaker state, kept in step with accepted words
    logic [gwwb_pkg::WIDTH_BITS-1:0] width_setting = gwwb_pkg::WIDTH_MAX;
    logic [gwwb_pkg::WIDTH_BITS-1:0] line_used     = '0;
    logic [gwwb_pkg::IDX_BITS-1:0]   word_begin    = '0;
    logic [gwwb_pkg::IDX_BITS-1:0]   last_break    = '0;
    logic [gwwb_pkg::IDX_BITS-1:0]   call_start    = '0;
    logic [gwwb_pkg::IDX_BITS-1:0]   newline_at    = '0;
    gwwb_pkg::phase_t                scan_phase    = gwwb_pkg::PH_DONE;

    gwwb_pkg::out_word_t expected_breaks[$];

    int  errors         = 0;
    int  words_sent     = 0;
    int  words_used     = 0;
    int  breaks_checked = 0;
    int  width_writes   = 0;
    int  idle_cycles    = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle        = 1'b1;
    bit  rx_idle        = 1'b1;

    greedy_word_wrap_breaker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void expect_break(input logic [gwwb_pkg::IDX_BITS-1:0] last_idx,
                                         input logic [gwwb_pkg::IDX_BITS-1:0] next_idx);
        gwwb_pkg::out_word_t r;
        r.line_last = last_idx;
        r.line_next = next_idx;
        expected_breaks = {expected_breaks, r};
        scan_phase = gwwb_pkg::PH_DONE;
    endfunction

    // returns 0 when the word falls outside a call and is dropped
    function automatic bit predict_break(input gwwb_pkg::in_word_t w);
        logic [gwwb_pkg::IDX_BITS-1:0] idx;
        logic [gwwb_pkg::WIDTH_BITS:0] sum;
        idx = w.index;
        if (w.first) begin
            call_start = idx;
            word_begin = idx;
            last_break = idx;
            line_used  = '0;
            newline_at = '0;
            scan_phase = gwwb_pkg::PH_SCAN;
        end
        case (scan_phase)
            gwwb_pkg::PH_SKIP: begin
                if (w.mode == gwwb_pkg::MODE_END || w.code != gwwb_pkg::CH_SPACE)
                    expect_break(newline_at, idx);
            end
            gwwb_pkg::PH_SCAN: begin
                if (w.mode == gwwb_pkg::MODE_END) begin
                    expect_break(idx, idx);
                end else begin
                    sum = {1'b0, line_used} + (gwwb_pkg::WIDTH_BITS + 1)'(w.advance);
                    line_used = sum[gwwb_pkg::WIDTH_BITS] ? gwwb_pkg::WIDTH_MAX
                                                          : sum[gwwb_pkg::WIDTH_BITS-1:0];
                    if (w.code == gwwb_pkg::CH_NEWLINE) begin
                        newline_at = idx;
                        scan_phase = gwwb_pkg::PH_SKIP;
                    end else if (w.code == gwwb_pkg::CH_SPACE ||
                                 w.code == gwwb_pkg::CH_HYPHEN) begin
                        // a word end only counts after a non-empty word
                        if (word_begin != idx)
                            last_break = idx;
                        word_begin = idx + 1'b1;
                    end else if (line_used >= width_setting) begin
                        if (last_break != call_start)
                            expect_break(last_break, word_begin);
                        else
                            expect_break(idx, idx);
                    end
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wen)
                width_setting = cfg_wdata;
            if (s_valid && s_ready) begin
                words_sent++;
                if (predict_break(s_word))
                    words_used++;
            end
            if (m_valid && m_ready) begin
                if (expected_breaks.size() == 0) begin
                    $display("%0t: unexpected line break last %0d next %0d",
                             $time, m_word.line_last, m_word.line_next);
                    errors++;
                end else begin
                    gwwb_pkg::out_word_t exp_word;
                    exp_word = expected_breaks.pop_front();
                    breaks_checked++;
                    if (m_word.line_last !== exp_word.line_last) begin
                        $display("%0t: line_last expected %0d got %0d",
                                 $time, exp_word.line_last, m_word.line_last);
                        errors++;
                    end
                    if (m_word.line_next !== exp_word.line_next) begin
                        $display("%0t: line_next expected %0d got %0d",
                                 $time, exp_word.line_next, m_word.line_next);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("greedy_word_wrap_breaker verification failed");
            $finish;
        end
    end

    // result side: random gaps per word, plus long hold-offs on request
    initial begin : result_sink
        int gap;
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && rx_hold_cycles == 0);
        end
    end

    function automatic gwwb_pkg::in_word_t char_word(
        input bit first,
        input logic [gwwb_pkg::IDX_BITS-1:0] idx,
        input logic [gwwb_pkg::CODE_BITS-1:0] code,
        input logic [gwwb_pkg::ADV_BITS-1:0] adv);
        gwwb_pkg::in_word_t w;
        w.mode    = gwwb_pkg::MODE_CHAR;
        w.first   = first;
        w.index   = idx;
        w.code    = code;
        w.advance = adv;
        return w;
    endfunction

    function automatic gwwb_pkg::in_word_t end_word(
        input bit first,
        input logic [gwwb_pkg::IDX_BITS-1:0] idx);
        gwwb_pkg::in_word_t w;
        w.mode    = gwwb_pkg::MODE_END;
        w.first   = first;
        w.index   = idx;
        w.code    = gwwb_pkg::CODE_BITS'($urandom_range(0, 'h10FFFF));
        w.advance = gwwb_pkg::ADV_BITS'($urandom);
        return w;
    endfunction

    function automatic logic [gwwb_pkg::CODE_BITS-1:0] random_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) return CH_LETTER_A + gwwb_pkg::CODE_BITS'($urandom_range(0, 25));
        if (r < 73) return gwwb_pkg::CH_SPACE;
        if (r < 81) return gwwb_pkg::CH_HYPHEN;
        if (r < 87) return gwwb_pkg::CH_NEWLINE;
        return gwwb_pkg::CODE_BITS'($urandom_range(0, 'h10FFFF));
    endfunction

    function automatic logic [gwwb_pkg::ADV_BITS-1:0] random_advance();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 3) return gwwb_pkg::ADV_BITS'($urandom);
        return gwwb_pkg::ADV_BITS'($urandom_range('h0400, 'h1400));
    endfunction

    task automatic send_word(input gwwb_pkg::in_word_t w);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // sender stops until every predicted break is back and the queue is empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_breaks.size() != 0) @(posedge aclk);
        repeat (gwwb_pkg::QUEUE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic set_width(input logic [gwwb_pkg::WIDTH_BITS-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        @(posedge aclk);
        width_writes++;
    endtask

    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // reset width, no call open yet: dropped, then a lone end marker
        send_word(char_word(1'b0, 16'd3, CH_LETTER_A, 16'hFFFF));
        send_word(end_word(1'b1, 16'hFFFF));
        // newline followed by spaces, then a letter
        send_word(char_word(1'b1, 16'd10, CH_LETTER_A, 16'h1000));
        send_word(char_word(1'b0, 16'd11, gwwb_pkg::CH_SPACE, 16'h0800));
        send_word(char_word(1'b0, 16'd12, gwwb_pkg::CH_NEWLINE, 16'h0000));
        send_word(char_word(1'b0, 16'd13, gwwb_pkg::CH_SPACE, 16'h0800));
        send_word(char_word(1'b0, 16'd14, gwwb_pkg::CH_SPACE, 16'h0800));
        send_word(char_word(1'b0, 16'd15, CH_LETTER_A, 16'h1000));
        // newline closed by the end marker
        send_word(char_word(1'b1, 16'd20, CH_LETTER_A, 16'h1000));
        send_word(char_word(1'b0, 16'd21, gwwb_pkg::CH_NEWLINE, 16'h0000));
        send_word(end_word(1'b0, 16'd22));
        // a new call cuts the open one short
        send_word(char_word(1'b1, 16'd30, CH_LETTER_A, 16'h1000));
        send_word(char_word(1'b0, 16'd31, CH_LETTER_A, 16'h1000));
        send_word(end_word(1'b1, 16'd40));
        wait_idle();

        set_width(24'h003000);
        // break after a hyphen
        send_word(char_word(1'b1, 16'd0, CH_LETTER_A, 16'h1000));
        send_word(char_word(1'b0, 16'd1, gwwb_pkg::CH_HYPHEN, 16'h0000));
        send_word(char_word(1'b0, 16'd2, CH_LETTER_A, 16'h1000));
        send_word(char_word(1'b0, 16'd3, CH_LETTER_A, 16'h1000));
        // next line start wraps past the top index
        send_word(char_word(1'b1, 16'hFFFE, CH_LETTER_A, 16'h1000));
        send_word(char_word(1'b0, 16'hFFFF, gwwb_pkg::CH_SPACE, 16'h0000));
        send_word(char_word(1'b0, 16'h0000, CH_LETTER_A, 16'h2000));
        wait_idle();

        set_width('0);
        // no word end seen: break on the character itself
        send_word(char_word(1'b1, 16'd5, 21'h10FFFF, 16'hFFFF));
        // leading space is not a word end
        send_word(char_word(1'b1, 16'd20, gwwb_pkg::CH_SPACE, 16'h0000));
        send_word(char_word(1'b0, 16'd21, CH_LETTER_A, 16'h0000));
        wait_idle();
    endtask

    task automatic test_saturation();
        tx_idle = 1'b0;
        set_width(gwwb_pkg::WIDTH_MAX);
        send_word(char_word(1'b1, 16'd0, CH_LETTER_A, 16'hFFFF));
        send_word(char_word(1'b0, 16'd1, gwwb_pkg::CH_SPACE, 16'hFFFF));
        // sum passes the top only on the 257th word; the last one is dropped
        for (int k = 2; k <= 257; k++)
            send_word(char_word(1'b0, k[gwwb_pkg::IDX_BITS-1:0], CH_LETTER_A, 16'hFFFF));
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_cycles = 80;
        // every end marker opening a call yields a break, so the block backs up
        for (int k = 0; k < 20; k++)
            send_word(end_word(1'b1, gwwb_pkg::IDX_BITS'($urandom)));
        wait_idle();
        rx_idle = 1'b1;
    endtask

    task automatic send_random_call();
        logic [gwwb_pkg::IDX_BITS-1:0] idx;
        int len;
        idx = ($urandom_range(0, 7) == 0)
              ? 16'hFFFF - gwwb_pkg::IDX_BITS'($urandom_range(0, 10))
              : gwwb_pkg::IDX_BITS'($urandom);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 16);
        if (len == 0) begin
            send_word(end_word(1'b1, idx));
        end else begin
            for (int k = 0; k < len; k++) begin
                send_word(char_word(k == 0, idx, random_code(), random_advance()));
                idx++;
            end
            // some calls are left without their end marker
            if ($urandom_range(0, 9) != 0)
                send_word(end_word(1'b0, idx));
        end
    endtask

    task automatic send_noise();
        gwwb_pkg::in_word_t w;
        int n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            w.mode    = 1'($urandom_range(0, 1));
            w.first   = ($urandom_range(0, 3) == 0);
            w.index   = gwwb_pkg::IDX_BITS'($urandom);
            w.code    = gwwb_pkg::CODE_BITS'($urandom_range(0, 'h10FFFF));
            w.advance = gwwb_pkg::ADV_BITS'($urandom);
            send_word(w);
        end
    endtask

    task automatic test_random();
        logic [gwwb_pkg::WIDTH_BITS-1:0] width_value;
        int target;
        int r;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       width_value = 24'h006000;
                1:       width_value = '0;
                2:       width_value = gwwb_pkg::WIDTH_MAX;
                3:       width_value = gwwb_pkg::WIDTH_BITS'($urandom_range('h2000, 'hC000));
                default: width_value = 24'h003000;
            endcase
            wait_idle();
            set_width(width_value);
            target = words_used + PHASE_WORDS;
            while (words_used < target) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 14);
                if (r == 0)
                    send_noise();
                else if (r == 1)
                    wait_idle();
                else
                    send_random_call();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_saturation();
        test_backpressure();
        test_random();
        wait_idle();
        if (expected_breaks.size() != 0) begin
            $display("%0t: %0d line breaks never arrived", $time, expected_breaks.size());
            errors++;
        end
        $display("run covered %0d words (%0d inside a call) and %0d line breaks",
                 words_sent, words_used, breaks_checked);
        $display("line width written %0d times, zero and full scale included, %0d mismatches",
                 width_writes, errors);
        if (errors == 0)
            $display("greedy_word_wrap_breaker verification clean");
        else
            $display("greedy_word_wrap_breaker verification failed");
        $finish;
    end

endmodule
